// ===== rtl/alx_pkg.sv =====
// Shared types, token kinds and the mnemonic table of the assembly token lexer.
`timescale 1ns / 1ps

package alx_pkg;

    localparam int KW_COUNT = 16;
    // Longest mnemonic; only this many leading letters of a word are kept.
    localparam int KW_BYTES = 7;

    localparam logic [4:0] KIND_ERR     = 5'd0;
    localparam logic [4:0] KIND_SPACE   = 5'd1;
    localparam logic [4:0] KIND_INT     = 5'd2;
    localparam logic [4:0] KIND_IDENT   = 5'd3;
    localparam logic [4:0] KIND_KW_BASE = 5'd4;

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_DIGIT = 2'd1,
        RUN_ALPHA = 2'd2
    } run_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  length;
        logic [7:0]  single_char;
        logic [15:0] row;
        logic [15:0] column;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic first;
        logic second;
    } q_push_t;

    typedef struct packed {
        logic valid;
        logic room;
    } q_status_t;

    // Text is right-justified: the first character sits in the highest used byte.
    localparam logic [KW_BYTES*8-1:0] KW_TEXT [KW_COUNT] = '{
        "push", "pop", "load", "add", "sub", "mult", "div", "cmp",
        "jmp", "je", "jge", "jg", "jle", "jl", "syscall", "nop"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd3, 4'd4, 4'd3, 4'd3, 4'd4, 4'd3, 4'd3,
        4'd3, 4'd2, 4'd3, 4'd2, 4'd3, 4'd2, 4'd7, 4'd3
    };

    // Word holds letter j of the run in byte j.
    function automatic logic [4:0] kw_kind(input logic [KW_BYTES*8-1:0] word,
                                           input logic [3:0] len,
                                           input logic long_run);
        logic [4:0] kind;
        logic       hit;
        kind = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            hit = (len == KW_LEN[i]);
            for (int j = 0; j < KW_BYTES; j++)
            begin
                if (j < int'(KW_LEN[i]))
                begin
                    hit = hit && (word[8*j +: 8] ==
                                  KW_TEXT[i][8*(int'(KW_LEN[i]) - 1 - j) +: 8]);
                end
            end
            if (hit && !long_run)
            begin
                kind = KIND_KW_BASE + 5'(i);
            end
        end
        return kind;
    endfunction

endpackage

// ===== rtl/alx_tok_queue.sv =====
// Four-entry shift queue that holds tokens until the output side takes them.
`timescale 1ns / 1ps

module alx_tok_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  alx_pkg::q_push_t  push,
    input  alx_pkg::tok_t     data0,
    input  alx_pkg::tok_t     data1,
    input  logic              pop,
    output alx_pkg::tok_t     head,
    output alx_pkg::q_status_t status
);
    import alx_pkg::*;

    localparam int DEPTH = 4;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_t             q_reg  [DEPTH];
    tok_t             q_next [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_kept;

    always_comb
    begin
        count_kept = count_reg - CNT_W'(pop);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (pop && i < DEPTH - 1)
                q_next[i] = q_reg[i + 1];
            else
                q_next[i] = q_reg[i];
            if (push.first && count_kept == CNT_W'(i))
                q_next[i] = data0;
            if (push.second && count_kept + 1'b1 == CNT_W'(i))
                q_next[i] = data1;
        end
        count_next = count_kept + CNT_W'(push.first) + CNT_W'(push.second);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign head         = q_reg[0];
    assign status.valid = (count_reg != '0);
    // Room for the two tokens that one character can cause at most.
    assign status.room  = (count_reg <= CNT_W'(DEPTH - 2));

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second token pushed without the first");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.first |-> status.room)
        else $error("token pushed into a full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!pop && !push.first) |=> count_reg == $past(count_reg))
        else $error("queue count moved without a push or pop");

endmodule

// ===== rtl/assembly_token_lexer.sv =====
// Top level of the assembly token lexer: character classifier, run state and output queue.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata = ch, tlast = end_of_input
//  m_axis    out  m_axis_tvalid/tready       tdata/tuser = token, tlast = last_result
//  tab_width in   tab_width_we               tab_width_wdata
//
// One character is taken per cycle while s_axis_tready is high; its tokens are computed in the
// same cycle and written into a four-entry output queue, whose registered head drives m_axis.
// A character that ends a run can give two tokens; the queue drains one per cycle while m_axis_tready
// is high, which sets the sustained rate: one beat per cycle while characters give one token.
// s_axis_tready is high while the queue has room for two tokens.
// rst_n clears the run state, the position to row 1 column 1 and the tab width to 8.
`timescale 1ns / 1ps

module assembly_token_lexer #(
    parameter int MAX_KEYWORD_LEN = 7,
    parameter int MAX_TOKEN_LEN   = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] token_length, [15:8] single_char,
                                        // [31:16] row, [47:32] column
    output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
    output logic        m_axis_tlast,
    input  logic        tab_width_we,
    input  logic [3:0]  tab_width_wdata
);
    import alx_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    logic [3:0]       tab_width_reg;
    run_t             run_type_reg, run_type_next;
    logic [LEN_W-1:0] run_len_reg, run_len_next;
    logic             run_long_reg, run_long_next;
    logic [7:0]       word_reg [KW_BYTES];
    logic [7:0]       word_next [KW_BYTES];
    logic [7:0]       first_reg, first_next;
    logic [15:0]      row_reg, row_next;
    logic [15:0]      col_reg, col_next;

    logic             accept;
    run_t             cls;
    logic             cont;
    logic             flush_old;
    logic             second_v;
    logic [LEN_W-1:0] len_base, len_app;
    logic             long_app;
    logic [KW_BYTES*8-1:0] word_old_flat, word_app_flat;
    logic [4:0]       kind_old, kind_new;
    logic [16:0]      pos_sum;
    tok_t             tok_old, tok_second;
    tok_t             data0, data1;
    q_push_t          push;
    q_status_t        status;
    tok_t             head;

    function automatic logic [7:0] sat_len(input logic [LEN_W-1:0] len);
        return (32'(len) > 255) ? 8'd255 : 8'(len);
    endfunction

    function automatic logic [3:0] kw_len_code(input logic [LEN_W-1:0] len);
        return (32'(len) > 15) ? 4'd15 : 4'(len);
    endfunction

    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (s_axis_tdata inside {["0":"9"]})
            cls = RUN_DIGIT;
        else if (s_axis_tdata inside {["a":"z"], ["A":"Z"]})
            cls = RUN_ALPHA;
        else
            cls = RUN_NONE;

        cont      = (run_type_reg != RUN_NONE) && (cls == run_type_reg);
        flush_old = (run_type_reg != RUN_NONE) && !cont;

        // Appending to the current run, or starting a new one with this letter or digit.
        len_base = cont ? run_len_reg : '0;
        long_app = (cont && run_long_reg) || (32'(len_base) >= MAX_KEYWORD_LEN) ||
                   (32'(len_base) >= MAX_TOKEN_LEN);
        len_app  = (32'(len_base) < MAX_TOKEN_LEN) ? len_base + 1'b1 : len_base;

        for (int j = 0; j < KW_BYTES; j++)
        begin
            word_old_flat[8*j +: 8] = word_reg[j];
            if (cls != RUN_NONE && 32'(len_base) == j)
                word_next[j] = s_axis_tdata;
            else
                word_next[j] = word_reg[j];
            word_app_flat[8*j +: 8] = word_next[j];
        end

        kind_old = (run_type_reg == RUN_DIGIT) ? KIND_INT :
                   kw_kind(word_old_flat, kw_len_code(run_len_reg), run_long_reg);
        kind_new = (cls == RUN_DIGIT) ? KIND_INT :
                   kw_kind(word_app_flat, kw_len_code(len_app), long_app);

        tok_old.kind        = kind_old;
        tok_old.length      = sat_len(run_len_reg);
        tok_old.single_char = first_reg;
        tok_old.row         = row_reg;
        tok_old.column      = col_reg;
        tok_old.last        = 1'b0;

        run_type_next = run_type_reg;
        run_len_next  = run_len_reg;
        run_long_next = run_long_reg;
        first_next    = first_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        pos_sum       = '0;

        tok_second.last = 1'b1;
        if (cls != RUN_NONE)
        begin
            second_v      = s_axis_tlast;
            first_next    = cont ? first_reg : s_axis_tdata;
            run_type_next = s_axis_tlast ? RUN_NONE : cls;
            run_len_next  = s_axis_tlast ? '0 : len_app;
            run_long_next = s_axis_tlast ? 1'b0 : long_app;
            tok_second.kind        = kind_new;
            tok_second.length      = sat_len(len_app);
            tok_second.single_char = first_next;
            tok_second.row         = row_reg;
            tok_second.column      = col_reg;
        end
        else
        begin
            second_v      = 1'b1;
            run_type_next = RUN_NONE;
            run_len_next  = '0;
            run_long_next = 1'b0;
            case (s_axis_tdata)
                " ":
                begin
                    pos_sum  = {1'b0, col_reg} + 17'd1;
                    col_next = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
                end
                8'h0A:
                begin
                    pos_sum  = {1'b0, row_reg} + 17'd1;
                    row_next = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
                    col_next = 16'd1;
                end
                8'h09:
                begin
                    pos_sum  = {1'b0, col_reg} + {13'd0, tab_width_reg};
                    col_next = pos_sum[16] ? 16'hFFFF : pos_sum[15:0];
                end
                default:
                begin
                    pos_sum = '0;
                end
            endcase
            // Position as it stands after this character has moved it.
            tok_second.kind = (s_axis_tdata == " " || s_axis_tdata == 8'h0A ||
                               s_axis_tdata == 8'h09) ? KIND_SPACE : KIND_ERR;
            tok_second.length      = 8'd1;
            tok_second.single_char = s_axis_tdata;
            tok_second.row         = row_next;
            tok_second.column      = col_next;
        end

        data1 = tok_second;
        if (flush_old)
        begin
            data0      = tok_old;
            data0.last = !second_v;
        end
        else
        begin
            data0 = tok_second;
        end

        push.first  = accept && (flush_old || second_v);
        push.second = accept && flush_old && second_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tab_width_reg <= 4'd8;
            run_type_reg  <= RUN_NONE;
            run_len_reg   <= '0;
            run_long_reg  <= 1'b0;
            row_reg       <= 16'd1;
            col_reg       <= 16'd1;
        end
        else
        begin
            if (tab_width_we)
                tab_width_reg <= tab_width_wdata;
            if (accept)
            begin
                run_type_reg <= run_type_next;
                run_len_reg  <= run_len_next;
                run_long_reg <= run_long_next;
                row_reg      <= row_next;
                col_reg      <= col_next;
            end
        end
    end

    // The word buffer and first character are read only while a run is pending.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg  <= word_next;
            first_reg <= first_next;
        end
    end

    alx_tok_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .data0  (data0),
        .data1  (data1),
        .pop    (m_axis_tvalid && m_axis_tready),
        .head   (head),
        .status (status)
    );

    assign s_axis_tready = status.room;
    assign m_axis_tvalid = status.valid;
    assign m_axis_tdata  = {head.column, head.row, head.single_char, head.length};
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;

endmodule
